// ===== rtl/plt_pkg.sv =====
// Shared types and constants of the per-process translation buffer.
package plt_pkg;
  localparam int PROCESSES  = 4;
  localparam int WAYS       = 8;
  localparam int PAGE_COUNT = 10;
  localparam int FRAME_BITS = 16;
  localparam int PID_W      = 2;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT        = PROCESSES * WAYS;
  localparam int ENT_W      = $clog2(ENT);
  localparam logic [31:0] AGE_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_LOOKUP    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_INV_PAGE  = 3'd2,
    OP_INV_FRAME = 3'd3,
    OP_FLUSH_P   = 3'd4,
    OP_FLUSH_ALL = 3'd5,
    OP_NOP6      = 3'd6,
    OP_NOP7      = 3'd7
  } op_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} bst_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t                   op;
    logic                  reject;
    logic [PID_W-1:0]      pid;
    logic [3:0]            page;
    logic [FRAME_BITS-1:0] frame;
  } cmd_t;
endpackage

// ===== rtl/plt_front.sv =====
// Front end: accepts requests, checks them and queues classified commands.
module plt_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_operation,
  input  logic [1:0]                 in_process_id,
  input  logic [3:0]                 in_page_number,
  input  logic [15:0]                in_frame_number,
  output logic                       q_valid,
  input  logic                       q_ready,
  output plt_pkg::cmd_t              q_cmd
);
  import plt_pkg::*;

  cmd_t cmd_in;
  logic proc_ok, page_ok, frame_ok;
  cmd_t slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wr_ptr_r, rd_ptr_r;
  logic push, pop;

  // Classify the incoming transaction
  always_comb begin
    proc_ok  = 32'(in_process_id) < PROCESSES;
    page_ok  = 32'(in_page_number) < PAGE_COUNT;
    frame_ok = in_frame_number[FRAME_BITS-1:0] != '0;
    cmd_in.op    = op_t'(in_operation);
    cmd_in.pid   = in_process_id;
    cmd_in.page  = in_page_number;
    cmd_in.frame = '0;
    cmd_in.frame = in_frame_number[FRAME_BITS-1:0];
    case (op_t'(in_operation))
      OP_LOOKUP, OP_INV_PAGE: cmd_in.reject = !proc_ok || !page_ok;
      OP_INSERT:              cmd_in.reject = !proc_ok || !page_ok || !frame_ok;
      OP_INV_FRAME:           cmd_in.reject = !frame_ok;
      OP_FLUSH_P:             cmd_in.reject = !proc_ok;
      default:                cmd_in.reject = 1'b0;
    endcase
  end

  // Two-entry queue
  assign in_ready = cnt_r != 2'd2;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot_r[rd_ptr_r];
  assign cnt_nxt  = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= cmd_in;
  end

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("push into full queue");
  a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("pop from empty queue");
`endif
endmodule

// ===== rtl/plt_back.sv =====
// Back end: walks the ways of the table one per cycle and answers each command.
module plt_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  plt_pkg::cmd_t              q_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [15:0]                out_found_frame,
  output logic                       out_status
);
  import plt_pkg::*;

  logic                  valid_r [ENT];
  logic [3:0]            page_r  [ENT];
  logic [FRAME_BITS-1:0] frame_r [ENT];
  logic [31:0]           age_r   [ENT];
  logic [31:0]           ctr_r;

  bst_t                  st_r, st_nxt;
  cmd_t                  cmd_r;
  logic [ENT_W:0]        idx_r, idx_nxt;
  logic [WAY_W-1:0]      vic_r, vic_nxt;
  logic [31:0]           old_r, old_nxt;
  logic                  have_r, have_nxt;
  logic                  hit_r, hit_nxt;
  logic [15:0]           fnd_r, fnd_nxt;
  logic                  stat_r, stat_nxt;

  logic [ENT_W-1:0]      ent;
  logic [WAY_W-1:0]      way;
  logic                  last;
  logic                  wr_ins, wr_stamp, clr_inv, clr_all;
  logic [ENT_W-1:0]      ins_ent;
  logic [31:0]           stamp;

  // Entry under scan: own process for per-process work, all entries otherwise
  always_comb begin
    way = '0;
    if (cmd_r.op == OP_INV_FRAME || cmd_r.op == OP_FLUSH_ALL) begin
      ent  = idx_r[ENT_W-1:0];
      last = idx_r == (ENT_W+1)'(ENT-1);
    end else begin
      way  = idx_r[WAY_W-1:0];
      ent  = ENT_W'(32'(cmd_r.pid) * WAYS + 32'(way));
      last = idx_r == (ENT_W+1)'(WAYS-1);
    end
  end

  assign stamp   = ctr_r;
  assign q_ready = st_r == S_IDLE;
  assign out_valid = st_r == S_DONE;
  assign out_hit = hit_r;
  assign out_found_frame = fnd_r;
  assign out_status = stat_r;

  // Sequencer
  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; vic_nxt = vic_r; old_nxt = old_r;
    have_nxt = have_r; hit_nxt = hit_r; fnd_nxt = fnd_r; stat_nxt = stat_r;
    wr_ins = 1'b0; wr_stamp = 1'b0; clr_inv = 1'b0; clr_all = 1'b0;
    ins_ent = ENT_W'(32'(cmd_r.pid) * WAYS + 32'(vic_r));
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          st_nxt = S_SCAN; idx_nxt = '0; have_nxt = 1'b0; vic_nxt = '0;
          old_nxt = '0; hit_nxt = 1'b0; fnd_nxt = '0; stat_nxt = q_cmd.reject;
          if (q_cmd.reject || q_cmd.op == OP_NOP6 || q_cmd.op == OP_NOP7)
            st_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (!last) idx_nxt = idx_r + 1'b1;
        else st_nxt = S_DONE;
        case (cmd_r.op)
          OP_LOOKUP: begin
            if (valid_r[ent] && page_r[ent] == cmd_r.page) begin
              wr_stamp = 1'b1; hit_nxt = 1'b1;
              fnd_nxt = 16'(frame_r[ent]); st_nxt = S_DONE;
            end
          end
          OP_INSERT: begin
            if (!valid_r[ent] || page_r[ent] == cmd_r.page) begin
              ins_ent = ent; wr_ins = 1'b1; st_nxt = S_DONE;
            end else begin
              if (!have_r || age_r[ent] < old_r) begin
                have_nxt = 1'b1; old_nxt = age_r[ent]; vic_nxt = way;
                if (last) ins_ent = ent;
              end
              if (last) wr_ins = 1'b1;
            end
          end
          OP_INV_PAGE: clr_inv = valid_r[ent] && page_r[ent] == cmd_r.page;
          OP_INV_FRAME: clr_inv = valid_r[ent] && frame_r[ent] == cmd_r.frame;
          OP_FLUSH_P, OP_FLUSH_ALL: clr_all = 1'b1;
          default: st_nxt = S_DONE;
        endcase
      end
      S_DONE: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ctr_r <= 32'd1;
      for (int i = 0; i < ENT; i++) valid_r[i] <= 1'b0;
      for (int i = 0; i < ENT; i++) begin
        page_r[i] <= '0; frame_r[i] <= '0; age_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      // Take a stamp and advance the saturating counter
      if (wr_stamp || wr_ins) begin
        if (ctr_r != AGE_MAX) ctr_r <= ctr_r + 32'd1;
      end
      if (wr_stamp) age_r[ent] <= stamp;
      if (wr_ins) begin
        valid_r[ins_ent] <= 1'b1; page_r[ins_ent] <= cmd_r.page;
        frame_r[ins_ent] <= cmd_r.frame; age_r[ins_ent] <= stamp;
      end
      if (clr_inv) begin
        valid_r[ent] <= 1'b0; frame_r[ent] <= '0;
      end
      if (clr_all) begin
        valid_r[ent] <= 1'b0; frame_r[ent] <= '0; page_r[ent] <= '0; age_r[ent] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid) cmd_r <= q_cmd;
    idx_r <= idx_nxt; vic_r <= vic_nxt; old_r <= old_nxt; have_r <= have_nxt;
    hit_r <= hit_nxt; fnd_r <= fnd_nxt; stat_r <= stat_nxt;
  end

`ifndef ASSERT_OFF
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_status && out_found_frame != '0)
    else $error("hit with reject or zero frame");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_frame))
    else $error("result dropped while stalled");
  a_ctr: assert property (@(posedge clk) disable iff (!rst_n) ctr_r != 32'd0)
    else $error("stamp counter wrapped");
`endif
endmodule

// ===== rtl/per_process_lru_tlb_top.sv =====
// Top level of the per-process translation buffer.
//   channel | direction | payload
//   in_     | input     | operation, process_id, page_number, frame_number
//   out_    | output    | hit, found_frame, status
// The front checks each transaction and queues it two deep; the back scans
// the ways of the table one per cycle. Rejected and unused items skip the
// scan; per-process work scans at most the eight ways of its process, and
// frame invalidate and flush all scan all 32 entries.
// Reset clears every entry at once and sets the stamp to 1.
// A stalled result holds the back; the front keeps queueing meanwhile until its two slots are full.
module per_process_lru_tlb_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [1:0]  in_process_id,
  input  logic [3:0]  in_page_number,
  input  logic [15:0] in_frame_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [15:0] out_found_frame,
  output logic        out_status
);
  import plt_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;

  plt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_process_id,
    .in_page_number, .in_frame_number, .q_valid, .q_ready, .q_cmd
  );

  plt_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready,
    .out_hit, .out_found_frame, .out_status
  );
endmodule
